### sv/nearest_palette_color_mapper_macros.svh
// Assertion macros for the top-level RTL file of the palette mapper.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`ifndef SYNTH
`define NPCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`define NPCM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define NPCM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons)
`endif
`endif

### sv/npcm_pkg.sv
package npcm_pkg;

  localparam int PALETTE_DEPTH_DEF = 128;

  localparam int IDX_W   = 7;
  localparam int COLOR_W = 24;
  localparam int PIXEL_W = 32;
  localparam int DIST_W  = 18;
  localparam int SIZE_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET  = 8'd16;
  localparam logic [DIST_W-1:0] LIMIT_RESET = 18'd100000;

  typedef enum logic {
    REG_SIZE  = 1'b0,
    REG_LIMIT = 1'b1
  } reg_sel_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [PIXEL_W-1:0] pixel;
    logic [DIST_W-1:0]  best;
    logic               hit;
  } beat_t;

endpackage

### sv/npcm_cell.sv
module npcm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  npcm_pkg::beat_t                  in_beat,
  input  logic [npcm_pkg::SIZE_W-1:0]      size,
  output logic                             out_vld,
  output npcm_pkg::beat_t                  out_beat
);

  logic [npcm_pkg::COLOR_W-1:0] entry_r;
  logic [npcm_pkg::COLOR_W-1:0] entry_nxt;
  logic                         vld_r;
  logic                         vld_nxt;
  npcm_pkg::beat_t              beat_r;
  npcm_pkg::beat_t              beat_nxt;

  logic [2*npcm_pkg::CHAN_W-1:0] sq_r;
  logic [2*npcm_pkg::CHAN_W-1:0] sq_g;
  logic [2*npcm_pkg::CHAN_W-1:0] sq_b;
  logic [npcm_pkg::DIST_W-1:0]   distance;
  logic                          active;
  logic                          better;
  logic                          wr_hit;

  function automatic logic [2*npcm_pkg::CHAN_W-1:0] chan_sq(
    input logic [npcm_pkg::CHAN_W-1:0] a,
    input logic [npcm_pkg::CHAN_W-1:0] b
  );
    logic [npcm_pkg::CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  always_comb begin
    sq_r     = chan_sq(in_beat.pixel[23:16], entry_r[23:16]);
    sq_g     = chan_sq(in_beat.pixel[15:8], entry_r[15:8]);
    sq_b     = chan_sq(in_beat.pixel[7:0], entry_r[7:0]);
    distance = npcm_pkg::DIST_W'(sq_r) + npcm_pkg::DIST_W'(sq_g)
             + npcm_pkg::DIST_W'(sq_b);
    active   = int'(size) > CELL_INDEX;
    better   = (in_beat.op == npcm_pkg::OP_PIXEL) && active && (distance < in_beat.best);
    wr_hit   = in_vld && (in_beat.op == npcm_pkg::OP_LOAD) && (int'(in_beat.idx) == CELL_INDEX);

    entry_nxt = entry_r;
    vld_nxt   = vld_r;
    beat_nxt  = beat_r;
    if (adv) begin
      vld_nxt  = in_vld;
      beat_nxt = in_beat;
      if (better) begin
        beat_nxt.best  = distance;
        beat_nxt.color = entry_r;
        beat_nxt.hit   = 1'b1;
      end
      if (wr_hit) begin
        entry_nxt = in_beat.color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    beat_r  <= beat_nxt;
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

### sv/nearest_palette_color_mapper.sv
// Nearest palette color mapper.
// Beats arrive on the in_ channel with valid and ready. A beat with in_op low
// loads in_entry_color into palette entry in_entry_index and gives no result.
// A beat with in_op high maps in_pixel_in to the first nearest active palette
// color whose squared RGB distance is strictly below the limit, else passes it
// through; the result leaves on the out_ channel as one beat.
// The palette lives in a chain of PALETTE_DEPTH cells, one entry per cell, and
// every beat walks the chain one cell per cycle unless the chain holds, so loads
// and pixels keep their order. A pixel's result is registered after the last
// cell, and one beat per cycle is sustained while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready drops until the result is taken.
// Reset empties the chain and sets palette_size to 16 and distance_limit to
// 100000; palette entries are undefined until loaded. The APB port holds
// palette_size at byte address 0 and distance_limit at address 4; it should
// be written only while no beat is in flight.
`include "nearest_palette_color_mapper_macros.svh"

module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [npcm_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [npcm_pkg::COLOR_W-1:0]      in_entry_color,
  input  logic [npcm_pkg::PIXEL_W-1:0]      in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npcm_pkg::PIXEL_W-1:0]      out_pixel_out,
  output logic                              out_replaced,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npcm_pkg::PADDR_W-1:0]      paddr,
  input  logic [npcm_pkg::PDATA_W-1:0]      pwdata,
  output logic [npcm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [npcm_pkg::SIZE_W-1:0]  size_r;
  logic [npcm_pkg::SIZE_W-1:0]  size_nxt;
  logic [npcm_pkg::DIST_W-1:0]  limit_r;
  logic [npcm_pkg::DIST_W-1:0]  limit_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [npcm_pkg::PIXEL_W-1:0] out_pixel_r;
  logic [npcm_pkg::PIXEL_W-1:0] out_pixel_nxt;
  logic                         out_replaced_r;
  logic                         out_replaced_nxt;
  logic                         adv;
  logic                         cfg_wr;
  npcm_pkg::reg_sel_t           cfg_sel;

  logic            chain_vld  [PALETTE_DEPTH+1];
  npcm_pkg::beat_t chain_beat [PALETTE_DEPTH+1];
  npcm_pkg::beat_t head;
  npcm_pkg::beat_t tail;

  assign adv     = !out_valid_r || out_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = npcm_pkg::reg_sel_t'(paddr[npcm_pkg::PADDR_W-1]);

  always_comb begin
    head.op    = npcm_pkg::op_t'(in_op);
    head.idx   = in_entry_index;
    head.color = in_entry_color;
    head.pixel = in_pixel_in;
    head.best  = limit_r;
    head.hit   = 1'b0;
  end

  assign chain_vld[0]  = in_valid;
  assign chain_beat[0] = head;

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (chain_vld[k]),
      .in_beat  (chain_beat[k]),
      .size     (size_r),
      .out_vld  (chain_vld[k+1]),
      .out_beat (chain_beat[k+1])
    );
  end

  assign tail = chain_beat[PALETTE_DEPTH];

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_pixel_nxt    = out_pixel_r;
    out_replaced_nxt = out_replaced_r;
    if (adv) begin
      out_valid_nxt    = chain_vld[PALETTE_DEPTH] && (tail.op == npcm_pkg::OP_PIXEL);
      out_pixel_nxt    = tail.hit ? {8'h00, tail.color} : tail.pixel;
      out_replaced_nxt = tail.hit;
    end
  end

  always_comb begin
    size_nxt  = size_r;
    limit_nxt = limit_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        npcm_pkg::REG_SIZE:  size_nxt  = pwdata[npcm_pkg::SIZE_W-1:0];
        npcm_pkg::REG_LIMIT: limit_nxt = pwdata[npcm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      npcm_pkg::REG_SIZE:  prdata = npcm_pkg::PDATA_W'(size_r);
      npcm_pkg::REG_LIMIT: prdata = npcm_pkg::PDATA_W'(limit_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= npcm_pkg::SIZE_RESET;
      limit_r     <= npcm_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r    <= out_pixel_nxt;
    out_replaced_r <= out_replaced_nxt;
  end

  assign in_ready      = adv;
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_replaced  = out_replaced_r;
  assign pready        = 1'b1;

  `NPCM_ASSERT_IMPL(a_replaced_alpha_zero, clk, rst_n, out_valid && out_replaced, out_pixel_out[31:24] == 8'h00)
  `NPCM_ASSERT_NEXT(a_load_gives_no_result, clk, rst_n, adv && chain_vld[PALETTE_DEPTH] && (tail.op == npcm_pkg::OP_LOAD), !out_valid_r)
  `NPCM_ASSERT_NEXT_ALWAYS(a_reset_empties_output, clk, !rst_n, !out_valid_r)

endmodule

### sim/npcm_mapping_checker.sv
`timescale 1ns / 1ps

module npcm_mapping_checker #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_op,
  input  logic [npcm_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [npcm_pkg::COLOR_W-1:0] in_entry_color,
  input  logic [npcm_pkg::PIXEL_W-1:0] in_pixel_in,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [npcm_pkg::PIXEL_W-1:0] out_pixel_out,
  input  logic                         out_replaced,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [npcm_pkg::PADDR_W-1:0] paddr,
  input  logic [npcm_pkg::PDATA_W-1:0] pwdata,
  output int                           error_count,
  output int                           pending_count,
  output int                           result_count,
  output int                           replace_count
);
  import npcm_pkg::*;

  localparam int SHOWN_MISMATCHES = 100;
  localparam int ENTRY_IW = $clog2(PALETTE_DEPTH);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               replaced;
  } mapped_t;

  logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
  logic [SIZE_W-1:0]  size_reg;
  logic [DIST_W-1:0]  limit_reg;
  mapped_t            mapped_pixels_q [$];

  initial begin
    error_count = 0;
    pending_count = 0;
    result_count = 0;
    replace_count = 0;
  end

  function automatic logic [DIST_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [DIST_W-1:0] d;
    d = (a >= b) ? DIST_W'(a - b) : DIST_W'(b - a);
    return d * d;
  endfunction

  // The first entry with the smallest distance below the limit wins.
  function automatic mapped_t nearest_color(input logic [PIXEL_W-1:0] px);
    mapped_t            res;
    logic [DIST_W-1:0]  best;
    logic [DIST_W-1:0]  distance;
    logic [COLOR_W-1:0] entry;
    int                 count;
    res.pixel = px;
    res.replaced = 1'b0;
    best = limit_reg;
    count = (int'(size_reg) > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_reg);
    for (int i = 0; i < count; i++) begin
      entry = palette[ENTRY_IW'(i)];
      distance = chan_sq(px[23:16], entry[23:16]) + chan_sq(px[15:8], entry[15:8])
               + chan_sq(px[7:0], entry[7:0]);
      if (distance < best) begin
        best = distance;
        res.pixel = {8'h00, entry};
        res.replaced = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [PIXEL_W-1:0] want,
                                 input logic [PIXEL_W-1:0] got);
    if (error_count < SHOWN_MISMATCHES) begin
      $display("%0t: %s mismatch, expected %08h, actual %08h", $time, field, want, got);
    end else if (error_count == SHOWN_MISMATCHES) begin
      $display("%0t: further mismatches are counted but not shown", $time);
    end
    error_count++;
  endtask

  always @(posedge clk) begin : track
    mapped_t want;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      limit_reg = LIMIT_RESET;
      mapped_pixels_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_sel_t'(paddr[2]))
          REG_SIZE:  size_reg = pwdata[SIZE_W-1:0];
          REG_LIMIT: limit_reg = pwdata[DIST_W-1:0];
          default:   ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (out_replaced === 1'b1) replace_count++;
        if (mapped_pixels_q.size() == 0) begin
          if (error_count < SHOWN_MISMATCHES) begin
            $display("%0t: result beat with nothing expected, actual pixel_out %08h replaced %0b",
                     $time, out_pixel_out, out_replaced);
          end
          error_count++;
        end else begin
          want = mapped_pixels_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            report_mismatch("pixel_out", want.pixel, out_pixel_out);
          end
          if (out_replaced !== want.replaced) begin
            report_mismatch("replaced", PIXEL_W'(want.replaced), PIXEL_W'(out_replaced));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (op_t'(in_op) == OP_PIXEL) begin
          mapped_pixels_q.push_back(nearest_color(in_pixel_in));
        end else begin
          palette[in_entry_index] = in_entry_color;
        end
      end
    end
    pending_count = mapped_pixels_q.size();
  end

endmodule

### sim/tb_nearest_palette_color_mapper.sv
`timescale 1ns / 1ps

module tb_nearest_palette_color_mapper;
  import npcm_pkg::*;

  localparam int DEPTH = PALETTE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS = 75;
  localparam logic [DIST_W-1:0] LIMIT_MAX = '1;
  localparam logic [DIST_W-1:0] FARTHEST = 18'd195075;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_op;
  logic [IDX_W-1:0]   in_entry_index;
  logic [COLOR_W-1:0] in_entry_color;
  logic [PIXEL_W-1:0] in_pixel_in;
  logic               out_valid;
  logic               out_ready;
  logic [PIXEL_W-1:0] out_pixel_out;
  logic               out_replaced;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int error_count;
  int pending_count;
  int result_count;
  int replace_count;

  logic [COLOR_W-1:0] palette_shadow [DEPTH];
  int                 active_count;
  logic               idle_on;
  int                 loads_sent;
  int                 pixels_sent;
  int                 settings_used;
  int                 cycle_count;

  nearest_palette_color_mapper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_replaced   (out_replaced),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  npcm_mapping_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_replaced   (out_replaced),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .replace_count  (replace_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_beat(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color, input logic [PIXEL_W-1:0] px);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_entry_index = idx;
    in_entry_color = color;
    in_pixel_in = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op == OP_LOAD) begin
      palette_shadow[idx] = color;
      loads_sent++;
    end else begin
      pixels_sent++;
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] color);
    send_beat(OP_LOAD, idx, color, $urandom());
  endtask

  task automatic map_pixel(input logic [PIXEL_W-1:0] px);
    send_beat(OP_PIXEL, IDX_W'($urandom()), COLOR_W'($urandom()), px);
  endtask

  task automatic cfg_write(input reg_sel_t sel, input logic [PDATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Loads give no result, so the chain gets a full pass after the last result.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] size, input logic [DIST_W-1:0] limit);
    wait_quiet();
    cfg_write(REG_SIZE, PDATA_W'(size));
    cfg_write(REG_LIMIT, PDATA_W'(limit));
    active_count = (int'(size) > DEPTH) ? DEPTH : int'(size);
    settings_used++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return SIZE_W'(1);
      1:       return SIZE_W'(2);
      2:       return SIZE_W'(DEPTH);
      3:       return SIZE_W'($urandom_range(DEPTH + 1, 255));
      4:       return SIZE_W'(0);
      default: return SIZE_W'($urandom_range(3, DEPTH - 1));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return DIST_W'(0);
      1:       return DIST_W'($urandom_range(1, 64));
      2:       return DIST_W'($urandom_range(65, 3000));
      3:       return DIST_W'(FARTHEST + 1);
      4:       return LIMIT_MAX;
      default: return DIST_W'($urandom());
    endcase
  endfunction

  // Most pixels land close to an active entry so that ties and the limit edge are hit.
  function automatic logic [PIXEL_W-1:0] pick_pixel();
    logic [PIXEL_W-1:0] px;
    logic [COLOR_W-1:0] base;
    int                 spread;
    int                 ch;
    px = $urandom();
    if (active_count > 0 && $urandom_range(0, 9) < 7) begin
      base = palette_shadow[IDX_W'($urandom_range(0, active_count - 1))];
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 2;
        2:       spread = 8;
        default: spread = 40;
      endcase
      for (int c = 0; c < 3; c++) begin
        ch = int'(base[8*c +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
        if (ch < 0) ch = 0;
        if (ch > 255) ch = 255;
        px[8*c +: 8] = 8'(ch);
      end
    end
    return px;
  endfunction

  initial begin
    logic [COLOR_W-1:0] color;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_entry_index = '0;
    in_entry_color = '0;
    in_pixel_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    loads_sent = 0;
    pixels_sent = 0;
    settings_used = 0;
    active_count = int'(SIZE_RESET);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Entries five to seven form ties: equal distances and a duplicate color.
    load_entry(IDX_W'(0), 24'h000000);
    load_entry(IDX_W'(1), 24'hffffff);
    load_entry(IDX_W'(2), 24'hff0000);
    load_entry(IDX_W'(3), 24'h00ff00);
    load_entry(IDX_W'(4), 24'h0000ff);
    load_entry(IDX_W'(5), 24'h808080);
    load_entry(IDX_W'(6), 24'h808082);
    load_entry(IDX_W'(7), 24'h808080);
    for (int i = 8; i < 16; i++) load_entry(IDX_W'(i), COLOR_W'($urandom()));
    map_pixel(32'h00000000);
    map_pixel(32'hffffffff);
    map_pixel(32'h7f808081);
    map_pixel(32'hc3808080);
    map_pixel(32'h5a123456);
    map_pixel(32'h80ff7f00);

    // Limit edges, an empty palette and the largest possible distance.
    set_config(SIZE_W'(16), DIST_W'(1));
    map_pixel(32'h00000001);
    map_pixel(32'hff000000);
    set_config(SIZE_W'(16), DIST_W'(0));
    map_pixel(32'h00000000);
    set_config(SIZE_W'(0), LIMIT_MAX);
    map_pixel(32'h12808080);
    set_config(SIZE_W'(1), FARTHEST);
    map_pixel(32'hffffffff);
    set_config(SIZE_W'(1), DIST_W'(FARTHEST + 1));
    map_pixel(32'hffffffff);

    for (int i = 0; i < DEPTH; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) begin
        color = palette_shadow[IDX_W'($urandom_range(0, i - 1))];
      end else begin
        color = COLOR_W'($urandom());
      end
      load_entry(IDX_W'(i), color);
    end

    set_config(SIZE_W'(255), LIMIT_MAX);
    repeat (20) map_pixel(pick_pixel());

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        set_config(SIZE_W'(DEPTH), LIMIT_RESET);
      end else begin
        set_config(pick_size(), pick_limit());
      end
      idle_on = (p == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PHASE_BEATS) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            color = palette_shadow[IDX_W'($urandom_range(0, DEPTH - 1))];
          end else begin
            color = COLOR_W'($urandom());
          end
          load_entry(IDX_W'($urandom()), color);
        end else begin
          map_pixel(pick_pixel());
        end
      end
    end

    wait_quiet();
    $display("Sent %0d palette loads and %0d pixels under %0d register settings.",
             loads_sent, pixels_sent, settings_used);
    $display("Checked %0d mapped pixels, %0d of them replaced by a palette color.",
             result_count, replace_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
